// File: rtl/lcs_pkg.sv
package lcs_pkg;

  localparam int unsigned MaxLenDefault = 32;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_RUN    = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] symbol;
  } lcs_in_t;

  typedef struct packed {
    logic [5:0] lcs_length;
    logic [7:0] symbol_res;
    logic       symbol_valid;
    logic       last;
  } lcs_out_t;

endpackage

// File: rtl/lcs_length_and_traceback.sv
// Longest common subsequence of two byte strings of up to MAX_LEN bytes.
// Load beats (func 0 and 1) are taken one per cycle and append a byte to the
// first or second string; extra bytes are dropped. A run beat (func 2) drives
// the first string's rows through a chain of MAX_LEN cells, one cell per column
// of the second string, row i entering the chain when the fill counter is i-1;
// each cell writes its scores into its own column memory. A traceback then
// walks the columns from the bottom-right cell, each step one registered read
// of the up and left neighbors followed by a move, and the subsequence bytes
// come out in forward order, one per beat, each beat held until it is taken
// before the next is formed. The input is not ready from the run beat until
// the last result beat is taken. Both string lengths clear after a run. An
// empty subsequence gives a single beat with symbol_valid low.
module lcs_length_and_traceback #(
  parameter int unsigned MAX_LEN = lcs_pkg::MaxLenDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcs_pkg::lcs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lcs_pkg::lcs_out_t out_data
);
  import lcs_pkg::*;

  localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
  localparam int unsigned IdxW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CntW  = $clog2(2 * MAX_LEN + 3);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FILL = 6'b000010,
    ST_RD   = 6'b000100,
    ST_STEP = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [7:0]      str_a [MAX_LEN];
  logic [7:0]      str_b [MAX_LEN];
  logic [LenW-1:0] len_a, len_b;
  logic [LenW-1:0] m, n;

  // fill control
  logic [CntW-1:0] fill_cnt;
  logic            feed_valid;
  logic [7:0]      feed_sym;

  logic            c_valid [MAX_LEN+1];
  logic [7:0]      c_sym   [MAX_LEN+1];
  logic [LenW-1:0] c_score [MAX_LEN+1];
  logic [LenW-1:0] c_diag  [MAX_LEN+1];
  logic [LenW-1:0] c_row   [MAX_LEN];
  logic [LenW-1:0] row_num [MAX_LEN+1];
  logic [LenW-1:0] col_last [MAX_LEN];
  logic [LenW-1:0] col_rd   [MAX_LEN];

  logic [7:0] match_buf [MAX_LEN];
  logic [LenW-1:0] ti, tj, k, r, lcs_len;
  logic [LenW-1:0] rd_up, rd_left;
  logic            accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  assign feed_valid = (state == ST_FILL) && (fill_cnt < CntW'(m));
  assign feed_sym   = str_a[fill_cnt[IdxW-1:0]];

  assign c_valid[0] = feed_valid;
  assign c_sym[0]   = feed_sym;
  assign c_score[0] = '0;
  assign c_diag[0]  = '0;
  assign row_num[0] = LenW'(fill_cnt + CntW'(1));

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    logic col_en;
    assign col_en = (LenW'(g) < n);
    lcs_cell #(.LenW(LenW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (state == ST_IDLE),
      .in_valid  (c_valid[g]),
      .in_sym    (c_sym[g]),
      .in_left   (c_score[g]),
      .in_diag   (c_diag[g]),
      .col_sym   (str_b[g]),
      .col_en    (col_en),
      .out_valid (c_valid[g+1]),
      .out_sym   (c_sym[g+1]),
      .out_score (c_score[g+1]),
      .out_up    (c_diag[g+1]),
      .out_col   (col_last[g])
    );
    always_ff @(posedge clk) begin
      row_num[g+1] <= row_num[g];
    end
    assign c_row[g] = row_num[g+1];
  end

  // One memory per column, rows 1..MAX_LEN at row-1. The traceback reads
  // column tj at row ti-1 (up) and every other column at row ti (left).
  for (genvar g = 0; g < MAX_LEN; g++) begin : g_tab
    logic [LenW-1:0] col_mem [MAX_LEN];
    logic [IdxW-1:0] rd_addr;
    logic [LenW-1:0] rd_q;
    assign rd_addr = (LenW'(g) == tj - LenW'(1)) ? IdxW'(ti - LenW'(2))
                                                 : IdxW'(ti - LenW'(1));
    always_ff @(posedge clk) begin
      if (c_valid[g+1]) begin
        col_mem[IdxW'(c_row[g] - LenW'(1))] <= c_score[g+1];
      end
      if (state == ST_RD) begin
        rd_q <= col_mem[rd_addr];
      end
    end
    assign col_rd[g] = rd_q;
  end

  assign rd_up   = (ti == LenW'(1)) ? '0 : col_rd[IdxW'(tj - LenW'(1))];
  assign rd_left = (tj == LenW'(1)) ? '0 : col_rd[IdxW'(tj - LenW'(2))];

  logic [7:0] a_sym, b_sym;
  assign a_sym = str_a[IdxW'(ti - LenW'(1))];
  assign b_sym = str_b[IdxW'(tj - LenW'(1))];

  always_ff @(posedge clk) begin
    if (accept && in_data.func == FUNC_LOAD_A && len_a < LenW'(MAX_LEN)) begin
      str_a[IdxW'(len_a)] <= in_data.symbol;
    end
    if (accept && in_data.func == FUNC_LOAD_B && len_b < LenW'(MAX_LEN)) begin
      str_b[IdxW'(len_b)] <= in_data.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len_a     <= '0;
      len_b     <= '0;
      out_valid <= 1'b0;
      fill_cnt  <= '0;
      k         <= '0;
      r         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.func == FUNC_LOAD_A && len_a < LenW'(MAX_LEN)) begin
              len_a <= len_a + LenW'(1);
            end
            if (in_data.func == FUNC_LOAD_B && len_b < LenW'(MAX_LEN)) begin
              len_b <= len_b + LenW'(1);
            end
            if (in_data.func == FUNC_RUN) begin
              m        <= len_a;
              n        <= len_b;
              len_a    <= '0;
              len_b    <= '0;
              fill_cnt <= '0;
              state    <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          fill_cnt <= fill_cnt + CntW'(1);
          if (fill_cnt == CntW'(m) + CntW'(MAX_LEN) + CntW'(1)) begin
            ti      <= m;
            tj      <= n;
            k       <= '0;
            lcs_len <= (n == '0) ? '0 : col_last[IdxW'(n - LenW'(1))];
            state   <= ST_RD;
          end
        end
        ST_RD: state <= ST_STEP;
        ST_STEP: begin
          // score along the path is lcs_len - k, so it hits zero at k == lcs_len
          if (ti == '0 || tj == '0 || k == lcs_len) begin
            r     <= '0;
            state <= ST_EMIT;
          end else begin
            state <= ST_RD;
            if (a_sym == b_sym) begin
              match_buf[IdxW'(k)] <= a_sym;
              k  <= k + LenW'(1);
              ti <= ti - LenW'(1);
              tj <= tj - LenW'(1);
            end else if (rd_up > rd_left) begin
              ti <= ti - LenW'(1);
            end else begin
              tj <= tj - LenW'(1);
            end
          end
        end
        ST_EMIT: begin
          out_valid <= 1'b1;
          out_data.lcs_length <= 6'(lcs_len);
          if (k == '0) begin
            out_data.symbol_res   <= '0;
            out_data.symbol_valid <= 1'b0;
            out_data.last         <= 1'b1;
          end else begin
            out_data.symbol_res   <= match_buf[IdxW'(k - LenW'(1) - r)];
            out_data.symbol_valid <= 1'b1;
            out_data.last         <= (r + LenW'(1) == k);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_data.last) begin
              state <= ST_IDLE;
            end else begin
              r     <= r + LenW'(1);
              state <= ST_EMIT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lcs_cell.sv
// One column of the score table. Each cycle with in_valid high, the row byte
// arrives from the left neighbor together with the left and diagonal scores;
// the cell produces its score for that row and passes the byte and scores on through output registers.
module lcs_cell #(
  parameter int unsigned LenW = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            in_valid,
  input  logic [7:0]      in_sym,
  input  logic [LenW-1:0] in_left,
  input  logic [LenW-1:0] in_diag,
  input  logic [7:0]      col_sym,
  input  logic            col_en,
  output logic            out_valid,
  output logic [7:0]      out_sym,
  output logic [LenW-1:0] out_score,
  output logic [LenW-1:0] out_up,
  output logic [LenW-1:0] out_col
);

  logic [LenW-1:0] up;
  logic [LenW-1:0] score_next;

  // Score of the latest row seen; after a fill this is the last row's score.
  assign out_col = up;

  always_comb begin
    if (!col_en) begin
      score_next = '0;
    end else if (in_sym == col_sym) begin
      score_next = in_diag + LenW'(1);
    end else if (up > in_left) begin
      score_next = up;
    end else begin
      score_next = in_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    if (clear) begin
      up <= '0;
    end else if (in_valid) begin
      up <= score_next;
    end
    out_sym   <= in_sym;
    out_score <= score_next;
  end

  // Up value as seen before this row's update, i.e. the next cell's diagonal.
  always_ff @(posedge clk) begin
    if (clear) begin
      out_up <= '0;
    end else if (in_valid) begin
      out_up <= up;
    end
  end

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  localparam int MaxLen = 32;

  class lcs_scoreboard;
    logic [7:0] str_a[MaxLen];
    logic [7:0] str_b[MaxLen];
    int len_a, len_b;
    lcs_out_t pending[$];
    int errors;

    function void clear();
      len_a = 0;
      len_b = 0;
      errors = 0;
      pending.delete();
    endfunction

    // Applies one accepted input beat and queues the beats it will produce.
    function void note_input(lcs_in_t it);
      int score[MaxLen+1][MaxLen+1];
      logic [7:0] rev[$];
      lcs_out_t o;
      int i, j, k;
      if (it.func == FUNC_LOAD_A) begin
        if (len_a < MaxLen) begin
          str_a[len_a] = it.symbol;
          len_a++;
        end
      end else if (it.func == FUNC_LOAD_B) begin
        if (len_b < MaxLen) begin
          str_b[len_b] = it.symbol;
          len_b++;
        end
      end else if (it.func == FUNC_RUN) begin
        for (i = 0; i <= len_a; i++) begin
          for (j = 0; j <= len_b; j++) begin
            if (i == 0 || j == 0) score[i][j] = 0;
            else if (str_a[i-1] == str_b[j-1]) score[i][j] = score[i-1][j-1] + 1;
            else score[i][j] = (score[i-1][j] > score[i][j-1]) ?
                               score[i-1][j] : score[i][j-1];
          end
        end
        i = len_a;
        j = len_b;
        while (i > 0 && j > 0 && score[i][j] != 0) begin
          if (str_a[i-1] == str_b[j-1]) begin
            rev.push_back(str_a[i-1]);
            i--;
            j--;
          end else if (score[i-1][j] > score[i][j-1]) i--;
          else j--;
        end
        if (rev.size() == 0) begin
          o = '0;
          o.last = 1'b1;
          pending.push_back(o);
        end else begin
          for (k = rev.size() - 1; k >= 0; k--) begin
            o.lcs_length = score[len_a][len_b][5:0];
            o.symbol_res = rev[k];
            o.symbol_valid = 1'b1;
            o.last = (k == 0);
            pending.push_back(o);
          end
        end
        len_a = 0;
        len_b = 0;
      end
    endfunction

    function void check_output(lcs_out_t got);
      lcs_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.lcs_length !== want.lcs_length) begin
        $display("%0t: lcs_length expected %0d actual %0d", $time, want.lcs_length,
                 got.lcs_length);
        errors++;
      end
      if (got.symbol_res !== want.symbol_res) begin
        $display("%0t: symbol_res expected %h actual %h", $time, want.symbol_res,
                 got.symbol_res);
        errors++;
      end
      if (got.symbol_valid !== want.symbol_valid) begin
        $display("%0t: symbol_valid expected %b actual %b", $time, want.symbol_valid,
                 got.symbol_valid);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  lcs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lcs_out_t out_data;

  lcs_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  lcs_length_and_traceback DUT (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(in_data);
    if (!rst && out_valid && out_ready) sb.check_output(out_data);
  end

  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Leaves valid high after the beat; the next send drops it only for idle gaps, drain takes it down.
  task automatic send(input logic [1:0] func, input logic [7:0] symbol);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: func, symbol: symbol};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic send_pair(input int la, input int lb, input int alpha);
    int i;
    for (i = 0; i < la; i++) send(FUNC_LOAD_A, 8'($urandom_range(alpha - 1)));
    for (i = 0; i < lb; i++) send(FUNC_LOAD_B, 8'($urandom_range(alpha - 1)));
    send(FUNC_RUN, 8'($urandom));
  endtask

  task automatic random_phase(input int items);
    int sent;
    int la, lb, r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // noise: stray loads, unused func, bare run
        send(2'($urandom_range(3)), 8'($urandom));
        sent++;
      end else begin
        la = (r < 18) ? $urandom_range(MaxLen + 3) : $urandom_range(8);
        lb = (r < 18) ? $urandom_range(MaxLen + 3) : $urandom_range(8);
        send_pair(la, lb, (r & 1) ? 4 : 256);
        sent += la + lb + 1;
      end
    end
  endtask

  initial begin
    int i;
    sb.clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty run, one-sided, identical, unused func, crossed pair, no match, full with overflow
    send(FUNC_RUN, 8'h00);
    send(FUNC_LOAD_A, 8'h00);
    send(FUNC_RUN, 8'hff);
    send(FUNC_LOAD_A, 8'hff);
    send(FUNC_LOAD_B, 8'hff);
    send(FUNC_RUN, 8'h00);
    send(2'd3, 8'haa);
    send(FUNC_LOAD_A, 8'h01);
    send(FUNC_LOAD_A, 8'h02);
    send(FUNC_LOAD_B, 8'h02);
    send(FUNC_LOAD_B, 8'h01);
    send(FUNC_RUN, 8'h00);
    send(FUNC_LOAD_A, 8'h55);
    send(FUNC_LOAD_B, 8'haa);
    send(FUNC_RUN, 8'h00);
    for (i = 0; i < MaxLen + 1; i++) send(FUNC_LOAD_A, 8'(i));
    for (i = 0; i < MaxLen + 1; i++) send(FUNC_LOAD_B, 8'(i));
    send(FUNC_RUN, 8'h00);
    drain();

    random_phase(80);
    send_idle_pct = 84;
    random_phase(60);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    random_phase(60);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    random_phase(60);
    // sender pauses until everything has drained
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(60);
    join
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lcs_pkg.sv
rtl/lcs_cell.sv
rtl/lcs_length_and_traceback.sv
tb/tb.sv
